[rtl/qnpr_pkg.sv]
// Shared types and constants for the quadratic nearest positive root unit.
package qnpr_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int ROOT_W = DATA_W - 1;

   typedef struct packed {
      logic signed [DATA_W-1:0] coef_a;
      logic signed [DATA_W-1:0] coef_b;
      logic signed [DATA_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              hit;
   } rsp_type;

   // control that travels along the cell chains with each item
   typedef struct packed {
      logic vld;
      logic hit;
   } ctl_type;

endpackage

[rtl/qnpr_sqrt_cell.sv]
// One restoring square-root cell: resolves one root bit per item per cycle.
module qnpr_sqrt_cell #(
   parameter int W      = 32,
   parameter int SIDE_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  qnpr_pkg::ctl_type ctl_in,
   input  logic [SIDE_W-1:0] side_in,
   input  logic [W+1:0]      rem_in,
   input  logic [W-1:0]      root_in,
   input  logic [2*W-1:0]    rad_in,
   output qnpr_pkg::ctl_type ctl_out,
   output logic [SIDE_W-1:0] side_out,
   output logic [W+1:0]      rem_out,
   output logic [W-1:0]      root_out,
   output logic [2*W-1:0]    rad_out
);
   import qnpr_pkg::*;

   ctl_type           ctl_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [W+1:0]      rem_ff, rem_in_c;
   logic [W-1:0]      root_ff, root_in_c;
   logic [2*W-1:0]    rad_ff;
   logic [W+3:0]      cur, trial, diff;
   logic              ge;

   always_comb begin
      cur       = {rem_in, rad_in[2*W-1 -: 2]};
      trial     = {2'b00, root_in, 2'b01};
      diff      = cur - trial;
      ge        = (cur >= trial);
      rem_in_c  = ge ? diff[W+1:0] : cur[W+1:0];
      root_in_c = {root_in[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      side_ff <= side_in;
      rem_ff  <= rem_in_c;
      root_ff <= root_in_c;
      rad_ff  <= {rad_in[2*W-3:0], 2'b00};
   end

   assign ctl_out  = ctl_ff;
   assign side_out = side_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign rad_out  = rad_ff;

endmodule

[rtl/qnpr_div_cell.sv]
// One restoring divider cell: resolves one quotient bit per item per cycle.
module qnpr_div_cell #(
   parameter int RW = 33,
   parameter int NW = 49
) (
   input  logic              clock,
   input  logic              reset,
   input  qnpr_pkg::ctl_type ctl_in,
   input  logic [RW-1:0]     den_in,
   input  logic [RW-1:0]     rem_in,
   input  logic [NW-1:0]     dvd_in,
   input  logic [NW-1:0]     quo_in,
   output qnpr_pkg::ctl_type ctl_out,
   output logic [RW-1:0]     den_out,
   output logic [RW-1:0]     rem_out,
   output logic [NW-1:0]     dvd_out,
   output logic [NW-1:0]     quo_out
);
   import qnpr_pkg::*;

   ctl_type       ctl_ff;
   logic [RW-1:0] den_ff, rem_ff, rem_next;
   logic [NW-1:0] dvd_ff, quo_ff;
   logic [RW:0]   cur, diff;
   logic          ge;

   always_comb begin
      cur      = {rem_in, dvd_in[NW-1]};
      diff     = cur - {1'b0, den_in};
      ge       = (cur >= {1'b0, den_in});
      rem_next = ge ? diff[RW-1:0] : cur[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_next;
      dvd_ff <= {dvd_in[NW-2:0], 1'b0};
      quo_ff <= {quo_in[NW-2:0], ge};
   end

   assign ctl_out = ctl_ff;
   assign den_out = den_ff;
   assign rem_out = rem_ff;
   assign dvd_out = dvd_ff;
   assign quo_out = quo_ff;

endmodule

[rtl/quadratic_nearest_positive_root_unit.sv]
// Top level: smallest positive root of a*x^2 + b*x + c in fixed point.
//
//   channel  ports                      direction  handshake
//   request  start, busy, req_data      in         start && !busy
//   result   rsp_valid, rsp_data        out        rsp_valid, one cycle
//
// One item per cycle through the sign split, product and discriminant stages,
// the square-root chain (one cell per root bit), the divider chain (one cell per
// quotient bit) and the output register; coefficients are Q16.16 by default.
// Synchronous reset clears every valid bit in the chains.
// busy is never raised; results cannot be stalled and leave in input order.
module quadratic_nearest_positive_root_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qnpr_pkg::req_type req_data,
   output logic              rsp_valid,
   output qnpr_pkg::rsp_type rsp_data
);
   import qnpr_pkg::*;

   localparam int DW  = DATA_W;
   localparam int RW  = DW + 1;
   localparam int NW  = DW + 1 + FRAC_W;
   localparam logic [NW-1:0] ROOT_MAX = {{(NW-ROOT_W){1'b0}}, {ROOT_W{1'b1}}};

   // stage 1: sign / magnitude split
   logic          s1_vld_ff, s1_cond_ff;
   logic [DW-1:0] s1_am_ff, s1_bm_ff, s1_cm_ff;
   logic [DW-1:0] am_in, bm_in, cm_in;
   logic          an, bn, cn;

   always_comb begin
      an    = req_data.coef_a[DW-1];
      bn    = req_data.coef_b[DW-1];
      cn    = req_data.coef_c[DW-1];
      am_in = an ? DW'(-req_data.coef_a) : DW'(req_data.coef_a);
      bm_in = bn ? DW'(-req_data.coef_b) : DW'(req_data.coef_b);
      cm_in = cn ? DW'(-req_data.coef_c) : DW'(req_data.coef_c);
   end

   // stage 2: products
   logic            s2_vld_ff, s2_cond_ff;
   logic [DW-1:0]   s2_am_ff, s2_bm_ff;
   logic [2*DW-1:0] s2_b2_ff, s2_ac_ff;

   // stage 3: discriminant
   ctl_type         s3_ctl_ff;
   logic [DW-1:0]   s3_am_ff, s3_bm_ff;
   logic [2*DW-1:0] s3_disc_ff;
   logic [2*DW+1:0] ac4;
   logic            disc_pos;

   always_comb begin
      ac4      = {s2_ac_ff, 2'b00};
      disc_pos = ({2'b00, s2_b2_ff} > ac4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_ctl_ff <= '0;
      end else begin
         s1_vld_ff     <= start && !busy;
         s2_vld_ff     <= s1_vld_ff;
         s3_ctl_ff.vld <= s2_vld_ff;
         s3_ctl_ff.hit <= s2_cond_ff && disc_pos;
      end
      s1_am_ff   <= am_in;
      s1_bm_ff   <= bm_in;
      s1_cm_ff   <= cm_in;
      s1_cond_ff <= (am_in != '0) && (bm_in != '0) && (bn != an) &&
                    (cm_in != '0) && (cn == an);
      s2_am_ff   <= s1_am_ff;
      s2_bm_ff   <= s1_bm_ff;
      s2_cond_ff <= s1_cond_ff;
      s2_b2_ff   <= s1_bm_ff * s1_bm_ff;
      s2_ac_ff   <= s1_am_ff * s1_cm_ff;
      s3_am_ff   <= s2_am_ff;
      s3_bm_ff   <= s2_bm_ff;
      s3_disc_ff <= s2_b2_ff - ac4[2*DW-1:0];
   end

   // square-root chain
   ctl_type         sq_ctl  [DW+1];
   logic [2*DW-1:0] sq_side [DW+1];
   logic [DW+1:0]   sq_rem  [DW+1];
   logic [DW-1:0]   sq_root [DW+1];
   logic [2*DW-1:0] sq_rad  [DW+1];

   assign sq_ctl[0]  = s3_ctl_ff;
   assign sq_side[0] = {s3_am_ff, s3_bm_ff};
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = s3_disc_ff;

   for (genvar i = 0; i < DW; i++) begin : g_sqrt
      qnpr_sqrt_cell #(.W(DW), .SIDE_W(2*DW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (sq_ctl[i]),
         .side_in  (sq_side[i]),
         .rem_in   (sq_rem[i]),
         .root_in  (sq_root[i]),
         .rad_in   (sq_rad[i]),
         .ctl_out  (sq_ctl[i+1]),
         .side_out (sq_side[i+1]),
         .rem_out  (sq_rem[i+1]),
         .root_out (sq_root[i+1]),
         .rad_out  (sq_rad[i+1])
      );
   end

   // divider chain: (|b| - sqrt(D)) * 2^FRAC / (2|a|)
   ctl_type       dv_ctl [NW+1];
   logic [RW-1:0] dv_den [NW+1];
   logic [RW-1:0] dv_rem [NW+1];
   logic [NW-1:0] dv_dvd [NW+1];
   logic [NW-1:0] dv_quo [NW+1];
   logic [DW-1:0] sq_am, sq_bm;
   logic [RW-1:0] numer;

   always_comb begin
      sq_am = sq_side[DW][2*DW-1:DW];
      sq_bm = sq_side[DW][DW-1:0];
      numer = {1'b0, sq_bm} - {1'b0, sq_root[DW]};
   end

   assign dv_ctl[0] = sq_ctl[DW];
   assign dv_den[0] = {sq_am, 1'b0};
   assign dv_rem[0] = '0;
   assign dv_dvd[0] = {numer, {FRAC_W{1'b0}}};
   assign dv_quo[0] = '0;

   for (genvar j = 0; j < NW; j++) begin : g_div
      qnpr_div_cell #(.RW(RW), .NW(NW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (dv_ctl[j]),
         .den_in  (dv_den[j]),
         .rem_in  (dv_rem[j]),
         .dvd_in  (dv_dvd[j]),
         .quo_in  (dv_quo[j]),
         .ctl_out (dv_ctl[j+1]),
         .den_out (dv_den[j+1]),
         .rem_out (dv_rem[j+1]),
         .dvd_out (dv_dvd[j+1]),
         .quo_out (dv_quo[j+1])
      );
   end

   // output register with saturation
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    sat;

   assign sat = (dv_quo[NW] > ROOT_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ctl[NW].vld;
      end
      rsp_data_ff.hit  <= dv_ctl[NW].hit;
      rsp_data_ff.root <= !dv_ctl[NW].hit ? '0 :
                          sat ? {ROOT_W{1'b1}} : dv_quo[NW][ROOT_W-1:0];
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> s1_vld_ff)
      else $error("accepted item did not enter the pipeline");

   a_hit_needs_sign_rule: assert property (@(posedge clock) disable iff (reset)
      s3_ctl_ff.hit |-> $past(s2_cond_ff))
      else $error("hit set without the sign conditions");

   a_miss_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (dv_ctl[NW].vld && !dv_ctl[NW].hit) |=>
         (rsp_valid && !rsp_data.hit && rsp_data.root == '0))
      else $error("miss item did not produce a zero result");

endmodule
